### rtl/gb3_pkg.sv
// Shared types and constants for the 3x3 Gaussian blur stream filter.
`default_nettype none

package gb3_pkg;

  // Field widths of the pixel and result channels.
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int COL_OUT_W  = 10;
  localparam int ROW_CNT_W  = 13;

  // Configuration register widths.
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int WT_W       = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;

  // Largest frame height and the reset values of the registers.
  localparam int ROWS_LIMIT       = 4096;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;
  localparam logic [WT_W-1:0] CENTRE_WT_RST = 17'd29174;
  localparam logic [WT_W-1:0] EDGE_WT_RST   = 17'd7275;
  localparam logic [WT_W-1:0] CORNER_WT_RST = 17'd1815;

  // Tap sums and products.
  localparam int TAPSUM_W = PIX_W + 2;
  localparam int PROD_C_W = PIX_W + WT_W;
  localparam int PROD_S_W = TAPSUM_W + WT_W;
  localparam int SUM_W    = PROD_S_W + 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_CENTRE_WEIGHT = 3'd2,
    REG_EDGE_WEIGHT   = 3'd3,
    REG_CORNER_WEIGHT = 3'd4
  } cfg_reg_t;

  // Request codes on the pixel channel.
  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_t;

  // One line memory entry: the pixels of the two previous rows at a column.
  typedef struct packed {
    logic [PIX_W-1:0] prev;
    logic [PIX_W-1:0] older;
  } line_entry_t;

  // One window column after vertical edge replication.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  // Position tags that travel with a result.
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } meta_t;

endpackage

`default_nettype wire

### rtl/gaussian_blur_3x3_stream.sv
// Top level of the 3x3 Gaussian blur stream filter with line memory and window.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+-------------------------------------------------
//   in      | in_valid/in_ready  | in_req_type, in_pixel_in
//   out     | out_valid/out_ready| out_pixel_out, out_row, out_col, out_frame_last
//   cfg     | cfg_wr_en          | cfg_index, cfg_wr_data
//
// One item per clock is accepted while not stalled; the single-port-per-direction line memory
// (one read at accept, one write when the item leaves the read stage) sets that rate.
// A result passes the read, sum and multiply stages and is then held in the output register.
// Reset (rst_n low, synchronous) restores the register defaults and clears the
// position counters and window; line memory contents are not cleared.
// A stalled output holds the pipeline stage by stage; empty stages still take items.
`default_nettype none

module gaussian_blur_3x3_stream #(
  parameter int MAX_WIDTH        = 1024,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration writes
  input  wire logic                                cfg_wr_en,
  input  wire logic [gb3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gb3_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
  // Pixel channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_req_type,
  input  wire logic [gb3_pkg::PIX_W-1:0]           in_pixel_in,
  // Result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [gb3_pkg::PIX_W-1:0]                out_pixel_out,
  output logic [gb3_pkg::ROW_W-1:0]                out_row,
  output logic [gb3_pkg::COL_OUT_W-1:0]            out_col,
  output logic                                     out_frame_last
);

  import gb3_pkg::*;

  localparam int COL_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RST_W_EFF    = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam logic [COL_W-1:0] RST_LAST_COL = COL_W'(RST_W_EFF - 1);
  localparam logic [ROW_W-1:0] RST_LAST_ROW = ROW_W'(FRAME_HEIGHT_RST - 1);
  localparam logic [SUM_W-1:0] PIX_MAX      = SUM_W'(255);

  // Geometry and weight registers.
  logic [COL_W-1:0]     last_col_r, last_col_nxt;
  logic [ROW_W-1:0]     last_row_r, last_row_nxt;
  logic [WT_W-1:0]      centre_wt_r, centre_wt_nxt;
  logic [WT_W-1:0]      edge_wt_r, edge_wt_nxt;
  logic [WT_W-1:0]      corner_wt_r, corner_wt_nxt;
  logic                 restart;

  // Position counters.
  logic [COL_W-1:0]     in_col_r, in_col_nxt;
  logic [ROW_CNT_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]     emit_col_r, emit_col_nxt;
  logic [ROW_W-1:0]     emit_row_r, emit_row_nxt;

  // Pipeline handshake.
  logic accept, act, emit, last_hit;
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_go, s2_go, s3_go;

  // Read stage payload.
  logic [PIX_W-1:0] s1_pixel_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_top_prev_r, s1_bot_prev_r, s1_emit_r;
  logic             s1_lclamp_r, s1_rclamp_r;
  meta_t            s1_meta_r;

  // Line memory and its forwarding path.
  line_entry_t      line_mem [MAX_WIDTH];
  line_entry_t      mem_q_r, fwd_data_r, rd_entry, wr_entry;
  logic             fwd_r;
  logic             mem_rd_en, mem_wr_en;

  // Window columns and the taps of the current result.
  col_t             b_col_r, c_col_r, new_col, left_col, right_col;
  logic [TAPSUM_W-1:0] edge_sum, corner_sum;

  // Sum and multiply stages.
  logic [PIX_W-1:0]    s2_cen_r;
  logic [TAPSUM_W-1:0] s2_edg_r, s2_cor_r;
  meta_t               s2_meta_r;
  logic [PROD_C_W-1:0] s3_pc_r;
  logic [PROD_S_W-1:0] s3_pe_r, s3_pk_r;
  meta_t               s3_meta_r;
  logic [SUM_W-1:0]    total_sum, shifted_sum;

  // Output register.
  logic [PIX_W-1:0]    out_pix_r;
  meta_t               out_meta_r;

  // Stage advance: each stage moves when the next one is empty or moving.
  assign s3_go    = s3_v_r && (!out_v_r || out_ready);
  assign s2_go    = s2_v_r && (!s3_v_r || s3_go);
  assign s1_go    = s1_v_r && (!s1_emit_r || !s2_v_r || s2_go);
  assign in_ready = !s1_v_r || s1_go;
  assign accept   = in_valid && in_ready;

  // A drain request while pixels are still expected is dropped.
  assign act = (in_req_type == REQ_PIXEL) || (in_row_r > {1'b0, last_row_r});

  // The first result appears one row and one pixel after the frame start.
  assign emit     = !((in_row_r == '0) || ((in_row_r == ROW_CNT_W'(1)) && (in_col_r == '0)));
  assign last_hit = (emit_row_r == last_row_r) && (emit_col_r == last_col_r);

  // Configuration decode with edge limiting of the geometry.
  always_comb begin
    last_col_nxt  = last_col_r;
    last_row_nxt  = last_row_r;
    centre_wt_nxt = centre_wt_r;
    edge_wt_nxt   = edge_wt_r;
    corner_wt_nxt = corner_wt_r;
    restart       = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          restart = 1'b1;
          if (cfg_wr_data[FW_W-1:0] == '0) begin
            last_col_nxt = '0;
          end else if (32'(cfg_wr_data[FW_W-1:0]) > 32'(MAX_WIDTH)) begin
            last_col_nxt = COL_W'(MAX_WIDTH - 1);
          end else begin
            last_col_nxt = COL_W'(cfg_wr_data[FW_W-1:0] - FW_W'(1));
          end
        end
        REG_FRAME_HEIGHT: begin
          restart = 1'b1;
          if (cfg_wr_data[FH_W-1:0] == '0) begin
            last_row_nxt = '0;
          end else if (cfg_wr_data[FH_W-1:0] > FH_W'(ROWS_LIMIT)) begin
            last_row_nxt = ROW_W'(ROWS_LIMIT - 1);
          end else begin
            last_row_nxt = ROW_W'(cfg_wr_data[FH_W-1:0] - FH_W'(1));
          end
        end
        REG_CENTRE_WEIGHT: centre_wt_nxt = cfg_wr_data[WT_W-1:0];
        REG_EDGE_WEIGHT:   edge_wt_nxt   = cfg_wr_data[WT_W-1:0];
        REG_CORNER_WEIGHT: corner_wt_nxt = cfg_wr_data[WT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input and result position counters; the frame restarts after its last result.
  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    emit_col_nxt = emit_col_r;
    emit_row_nxt = emit_row_r;
    if (restart) begin
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      emit_col_nxt = '0;
      emit_row_nxt = '0;
    end else if (accept && act) begin
      if (in_col_r == last_col_r) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_CNT_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (emit) begin
        if (last_hit) begin
          in_col_nxt   = '0;
          in_row_nxt   = '0;
          emit_col_nxt = '0;
          emit_row_nxt = '0;
        end else if (emit_col_r == last_col_r) begin
          emit_col_nxt = '0;
          emit_row_nxt = emit_row_r + ROW_W'(1);
        end else begin
          emit_col_nxt = emit_col_r + COL_W'(1);
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r  <= RST_LAST_COL;
      last_row_r  <= RST_LAST_ROW;
      centre_wt_r <= CENTRE_WT_RST;
      edge_wt_r   <= EDGE_WT_RST;
      corner_wt_r <= CORNER_WT_RST;
      in_col_r    <= '0;
      in_row_r    <= '0;
      emit_col_r  <= '0;
      emit_row_r  <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      fwd_r       <= 1'b0;
      b_col_r     <= '0;
      c_col_r     <= '0;
    end else begin
      last_col_r  <= last_col_nxt;
      last_row_r  <= last_row_nxt;
      centre_wt_r <= centre_wt_nxt;
      edge_wt_r   <= edge_wt_nxt;
      corner_wt_r <= corner_wt_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      emit_col_r  <= emit_col_nxt;
      emit_row_r  <= emit_row_nxt;
      // Stage valid flags.
      if (accept && act) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go && s1_emit_r) begin
        s2_v_r <= 1'b1;
      end else if (s2_go) begin
        s2_v_r <= 1'b0;
      end
      if (s2_go) begin
        s3_v_r <= 1'b1;
      end else if (s3_go) begin
        s3_v_r <= 1'b0;
      end
      if (s3_go) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      // Forward the entry being written when the next item reads the same column.
      if (mem_rd_en) begin
        fwd_r <= mem_wr_en && (s1_col_r == in_col_r);
      end
      // Window columns shift as each item leaves the read stage.
      if (s1_go) begin
        b_col_r <= c_col_r;
        c_col_r <= new_col;
      end
    end
  end

  // Read stage payload, captured at each transfer on the pixel channel that is not a dropped drain.
  always_ff @(posedge clk) begin
    if (accept && act) begin
      s1_pixel_r     <= in_pixel_in;
      s1_col_r       <= in_col_r;
      s1_top_prev_r  <= (in_row_r == ROW_CNT_W'(1));
      s1_bot_prev_r  <= (in_row_r == ({1'b0, last_row_r} + ROW_CNT_W'(1)));
      s1_emit_r      <= emit;
      s1_lclamp_r    <= (emit_col_r == '0);
      s1_rclamp_r    <= (emit_col_r == last_col_r);
      s1_meta_r.row  <= emit_row_r;
      s1_meta_r.col  <= COL_OUT_W'(emit_col_r);
      s1_meta_r.last <= last_hit;
    end
  end

  // Line memory: read at accept, write back when the item leaves the read stage.
  assign mem_rd_en = accept && act;
  assign mem_wr_en = s1_go;
  assign rd_entry  = fwd_r ? fwd_data_r : mem_q_r;

  always_comb begin
    wr_entry.prev  = s1_pixel_r;
    wr_entry.older = rd_entry.prev;
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      line_mem[s1_col_r] <= wr_entry;
    end
    if (mem_rd_en) begin
      mem_q_r    <= line_mem[in_col_r];
      fwd_data_r <= wr_entry;
    end
  end

  // New column with the top and bottom rows replicated at the frame edges.
  always_comb begin
    new_col.top = s1_top_prev_r ? rd_entry.prev : rd_entry.older;
    new_col.mid = rd_entry.prev;
    new_col.bot = s1_bot_prev_r ? rd_entry.prev : s1_pixel_r;
  end

  // Left and right columns replicate the centre column at the frame sides.
  assign left_col  = s1_lclamp_r ? c_col_r : b_col_r;
  assign right_col = s1_rclamp_r ? c_col_r : new_col;

  // Taps sharing a weight are added before the multiply.
  assign edge_sum   = TAPSUM_W'(c_col_r.top) + TAPSUM_W'(c_col_r.bot)
                    + TAPSUM_W'(left_col.mid) + TAPSUM_W'(right_col.mid);
  assign corner_sum = TAPSUM_W'(left_col.top) + TAPSUM_W'(left_col.bot)
                    + TAPSUM_W'(right_col.top) + TAPSUM_W'(right_col.bot);

  // Sum, multiply and output stages.
  assign total_sum   = SUM_W'(s3_pc_r) + SUM_W'(s3_pe_r) + SUM_W'(s3_pk_r);
  assign shifted_sum = total_sum >> WEIGHT_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit_r) begin
      s2_cen_r  <= c_col_r.mid;
      s2_edg_r  <= edge_sum;
      s2_cor_r  <= corner_sum;
      s2_meta_r <= s1_meta_r;
    end
    if (s2_go) begin
      s3_pc_r   <= PROD_C_W'(s2_cen_r) * PROD_C_W'(centre_wt_r);
      s3_pe_r   <= PROD_S_W'(s2_edg_r) * PROD_S_W'(edge_wt_r);
      s3_pk_r   <= PROD_S_W'(s2_cor_r) * PROD_S_W'(corner_wt_r);
      s3_meta_r <= s2_meta_r;
    end
    if (s3_go) begin
      out_pix_r  <= (shifted_sum > PIX_MAX) ? PIX_W'(255) : shifted_sum[PIX_W-1:0];
      out_meta_r <= s3_meta_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_pixel_out  = out_pix_r;
  assign out_row        = out_meta_r.row;
  assign out_col        = out_meta_r.col;
  assign out_frame_last = out_meta_r.last;

endmodule

`default_nettype wire

### tb/sv/gaussian_blur_3x3_stream_test.sv
// Self-checking testbench for the 3x3 Gaussian blur stream filter.
module gaussian_blur_3x3_stream_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gb3_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int FRAC_BITS     = 16;
  localparam int HIST_DEPTH    = 2 * MAX_WIDTH + 4;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 2000;

  // One item for the pixel channel.
  typedef struct {
    req_t             kind;
    logic [PIX_W-1:0] level;
  } pixel_req_t;

  // One filtered pixel with its position tags.
  typedef struct {
    logic [PIX_W-1:0]     level;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } blur_result_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = 1'b0;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [PIX_W-1:0]      out_pixel_out;
  logic [ROW_W-1:0]      out_row;
  logic [COL_OUT_W-1:0]  out_col;
  logic                  out_frame_last;

  gaussian_blur_3x3_stream uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_frame_last(out_frame_last)
  );

  // Predictor state: registers, pixel history and position counters.
  int unsigned      width_reg  = FRAME_WIDTH_RST;
  int unsigned      height_reg = FRAME_HEIGHT_RST;
  logic [WT_W-1:0]  centre_wt  = CENTRE_WT_RST;
  logic [WT_W-1:0]  edge_wt    = EDGE_WT_RST;
  logic [WT_W-1:0]  corner_wt  = CORNER_WT_RST;
  logic [PIX_W-1:0] line_hist [HIST_DEPTH] = '{default: '0};
  int unsigned      col_in  = 0;
  int unsigned      row_in  = 0;
  int unsigned      col_out = 0;
  int unsigned      row_out = 0;

  pixel_req_t   pixel_backlog[$];
  blur_result_t expected_pixels[$];
  blur_result_t want;
  int unsigned  fail_count   = 0;
  int unsigned  random_items = 0;

  // Sender and receiver idling state.
  bit           in_fired      = 1'b0;
  bit           sender_bursty = 1'b0;
  int unsigned  burst_left    = 0;
  int unsigned  gap_left      = 0;
  logic [15:0]  stall_pattern = 16'hFFFF;
  logic [5:0]   stall_tick    = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > ROWS_LIMIT) return ROWS_LIMIT;
    return height_reg;
  endfunction

  function automatic int clip(input int v, input int limit);
    if (v < 0) return 0;
    if (v > limit - 1) return limit - 1;
    return v;
  endfunction

  // Weighted 3x3 sum around (r, c) with edge replication, truncated and clamped.
  function automatic logic [PIX_W-1:0] blur_at(input int r, input int c, input int w,
                                               input int h);
    longint unsigned acc;
    int              dy;
    int              dx;
    int              y;
    int              x;
    logic [WT_W-1:0] wt;
    acc = 0;
    for (dy = -1; dy <= 1; dy++) begin
      for (dx = -1; dx <= 1; dx++) begin
        y = clip(r + dy, h);
        x = clip(c + dx, w);
        if (dy == 0 && dx == 0) wt = centre_wt;
        else if (dy == 0 || dx == 0) wt = edge_wt;
        else wt = corner_wt;
        acc = acc + 64'(line_hist[(y * w + x) % HIST_DEPTH]) * 64'(wt);
      end
    end
    acc = acc >> FRAC_BITS;
    return (acc > 255) ? 8'hFF : 8'(acc);
  endfunction

  task automatic restart_frame();
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;
  endtask

  // Advance the predictor by one accepted item and queue the result it completes.
  task automatic blur_step(input req_t kind, input logic [PIX_W-1:0] level);
    int unsigned  w;
    int unsigned  h;
    int unsigned  total;
    int unsigned  n;
    blur_result_t res;
    w     = eff_width();
    h     = eff_height();
    total = w * h;
    n     = row_in * w + col_in;
    if (kind == REQ_PIXEL) begin
      if (n < total) line_hist[n % HIST_DEPTH] = level;
    end else if (n < total) begin
      // A drain while the frame still wants pixels is ignored.
      return;
    end
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (n < w + 1) return;
    res.level = blur_at(row_out, col_out, w, h);
    res.row   = ROW_W'(row_out);
    res.col   = COL_OUT_W'(col_out);
    res.last  = (row_out * w + col_out + 1 >= total);
    expected_pixels.push_back(res);
    if (res.last) begin
      restart_frame();
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
  endtask

  // Register write; the predictor follows at once since the block is idle.
  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= CFG_DATA_W'(value);
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = value & 32'h7FF;
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = value & 32'h1FFF;
        restart_frame();
      end
      REG_CENTRE_WEIGHT: centre_wt = WT_W'(value);
      REG_EDGE_WEIGHT:   edge_wt   = WT_W'(value);
      REG_CORNER_WEIGHT: corner_wt = WT_W'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_weights(input int unsigned c, input int unsigned e,
                               input int unsigned k);
    write_reg(REG_CENTRE_WEIGHT, c);
    write_reg(REG_EDGE_WEIGHT, e);
    write_reg(REG_CORNER_WEIGHT, k);
  endtask

  // Gaussian-like, unit-range or full-field weights.
  task automatic shuffle_weights();
    case ($urandom_range(0, 2))
      0: write_weights($urandom_range(20000, 40000), $urandom_range(4000, 9000),
                       $urandom_range(1000, 3000));
      1: write_weights($urandom_range(0, 65536), $urandom_range(0, 65536),
                       $urandom_range(0, 65536));
      default: write_weights($urandom_range(0, 131071), $urandom_range(0, 131071),
                             $urandom_range(0, 131071));
    endcase
  endtask

  task automatic queue_item(input req_t kind, input logic [PIX_W-1:0] level);
    pixel_req_t item;
    item.kind  = kind;
    item.level = level;
    pixel_backlog.push_back(item);
  endtask

  // Wait until every item is taken and every result has arrived, plus the pipeline depth.
  task automatic settle();
    do @(posedge clk);
    while (pixel_backlog.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    // The next phase gets its own sender idling.
    sender_bursty = ($urandom_range(0, 2) != 0);
  endtask

  // Queue one frame: pixels with stray early drains, then an optional tail of drains
  // and surplus pixels. A weight rewrite can be placed in the middle of the frame.
  task automatic send_frame(input int unsigned pix_count, input bit with_tail,
                            input int unsigned pause_at);
    int unsigned      style;
    int unsigned      i;
    logic [PIX_W-1:0] level;
    style = $urandom_range(0, 2);
    for (i = 0; i < pix_count; i++) begin
      if (pause_at != 0 && i == pause_at) begin
        settle();
        shuffle_weights();
      end
      if ($urandom_range(0, 31) == 0) queue_item(REQ_DRAIN, 8'($urandom));
      case (style)
        0: level = 8'($urandom_range(0, 255));
        1: level = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: level = $urandom_range(0, 1) ? 8'($urandom_range(250, 255))
                                              : 8'($urandom_range(0, 5));
      endcase
      queue_item(REQ_PIXEL, level);
      random_items++;
    end
    if (with_tail) begin
      for (i = 0; i <= eff_width(); i++) begin
        if ($urandom_range(0, 3) == 0) queue_item(REQ_PIXEL, 8'($urandom));
        else queue_item(REQ_DRAIN, 8'($urandom));
        random_items++;
      end
    end
  endtask

  // Input transfer: predict, then retire the item from the backlog.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      blur_step(req_t'(in_req_type), in_pixel_in);
      void'(pixel_backlog.pop_front());
      in_fired = 1'b1;
    end
  end

  // Sender: when bursty, bursts of random length separated by random gaps; otherwise items back to back.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fired)) begin
      in_fired = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pixel_backlog.size() != 0) begin
        in_valid    <= 1'b1;
        in_req_type <= pixel_backlog[0].kind;
        in_pixel_in <= pixel_backlog[0].level;
        if (sender_bursty) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 16);
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: ready follows a random 16-bit pattern that is redrawn each time the 6-bit tick wraps.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_tick == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'hFFFF;
          1: stall_pattern = 16'($urandom) | 16'h0001;
          2: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
          default: stall_pattern = ~(16'h0001 << $urandom_range(0, 15));
        endcase
      end
      out_ready <= stall_pattern[stall_tick[3:0]];
      stall_tick = stall_tick + 6'd1;
    end
  end

  // Result transfer: compare against the oldest expected pixel.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result transfer with none expected: row %0d col %0d", out_row, out_col);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_out !== want.level) begin
          $error("pixel_out mismatch: expected %0d, actual %0d", want.level, out_pixel_out);
          fail_count++;
        end
        if (out_row !== want.row) begin
          $error("out_row mismatch: expected %0d, actual %0d", want.row, out_row);
          fail_count++;
        end
        if (out_col !== want.col) begin
          $error("out_col mismatch: expected %0d, actual %0d", want.col, out_col);
          fail_count++;
        end
        if (out_frame_last !== want.last) begin
          $error("frame_last mismatch: expected %0d, actual %0d", want.last, out_frame_last);
          fail_count++;
        end
      end
    end
  end

  // Stimulus phases.
  initial begin
    int unsigned k;
    int unsigned total;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Part of a frame at the reset geometry and weights; the geometry write below
    // cuts it short.
    repeat (700) queue_item(REQ_PIXEL, 8'($urandom));
    settle();

    // Small frame with extremes, early drains and a surplus pixel in the tail.
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    queue_item(REQ_DRAIN, 8'hA5);
    queue_item(REQ_PIXEL, 8'h00);
    queue_item(REQ_PIXEL, 8'hFF);
    queue_item(REQ_PIXEL, 8'h00);
    queue_item(REQ_DRAIN, 8'h5A);
    queue_item(REQ_PIXEL, 8'hFF);
    queue_item(REQ_PIXEL, 8'hFF);
    queue_item(REQ_PIXEL, 8'h00);
    queue_item(REQ_PIXEL, 8'hFF);
    queue_item(REQ_PIXEL, 8'h80);
    queue_item(REQ_PIXEL, 8'h07);
    queue_item(REQ_DRAIN, 8'h00);
    queue_item(REQ_PIXEL, 8'hC8);
    queue_item(REQ_DRAIN, 8'hFF);
    queue_item(REQ_DRAIN, 8'h00);
    // All-white frame: the reset weights sum just below one, so truncation shows.
    repeat (9) queue_item(REQ_PIXEL, 8'hFF);
    repeat (4) queue_item(REQ_DRAIN, 8'h00);
    settle();

    // Weight extremes: identity, full-field clamp, all zero, corners only.
    for (k = 0; k < 4; k++) begin
      write_reg(REG_FRAME_WIDTH, $urandom_range(1, 6));
      write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 4));
      case (k)
        0: write_weights(65536, 0, 0);
        1: write_weights(131071, 131071, 131071);
        2: write_weights(0, 0, 0);
        default: write_weights(0, 0, 65536);
      endcase
      total = eff_width() * eff_height();
      send_frame(total, 1'b1, 0);
      send_frame(total, 1'b1, 0);
      settle();
    end

    // Geometry extremes, including values that clamp.
    for (k = 0; k < 4; k++) begin
      case (k)
        0: begin
          write_reg(REG_FRAME_WIDTH, 0);
          write_reg(REG_FRAME_HEIGHT, 0);
        end
        1: begin
          write_reg(REG_FRAME_WIDTH, MAX_WIDTH);
          write_reg(REG_FRAME_HEIGHT, 2);
        end
        2: begin
          write_reg(REG_FRAME_WIDTH, 2047);
          write_reg(REG_FRAME_HEIGHT, 1);
        end
        default: begin
          write_reg(REG_FRAME_WIDTH, 1);
          write_reg(REG_FRAME_HEIGHT, 8191);
        end
      endcase
      shuffle_weights();
      send_frame(eff_width() * eff_height(), 1'b1, 0);
      settle();
    end

    // Random phases of small frames; some with a weight change mid-frame,
    // some ending in a frame that the next geometry write abandons.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) write_reg(REG_FRAME_WIDTH, $urandom_range(9, 40));
      else write_reg(REG_FRAME_WIDTH, $urandom_range(1, 8));
      write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 6));
      if ($urandom_range(0, 3) != 0) shuffle_weights();
      total = eff_width() * eff_height();
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 2) == 0) send_frame(total, 1'b1, $urandom_range(1, total - 1));
        else send_frame(total, 1'b1, 0);
      end
      if ($urandom_range(0, 3) == 0) send_frame($urandom_range(1, total), 1'b0, 0);
      settle();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(15_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
